// ----- rtl/disk_head_seek_scheduler_top_defines.svh -----
// Assertion macros for the disk head seek scheduler.
// Used by the top level; no other dependencies.
`ifndef DISK_HEAD_SEEK_SCHEDULER_TOP_DEFINES_SVH
`define DISK_HEAD_SEEK_SCHEDULER_TOP_DEFINES_SVH

// Implication checked on every clock edge, skipped while in reset.
`define DHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while in reset.
`define DHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dhss_pkg.sv -----
// Shared constants and types for the disk head seek scheduler.
// No dependencies.
package dhss_pkg;

    localparam int MAX_REQUESTS_DEF  = 32;
    localparam int CYLINDER_BITS_DEF = 16;

    localparam int SEEK_W  = 22;
    localparam int COUNT_W = 6;
    localparam int CFG_W   = 17;
    localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

    // Register indexes
    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_CYLCNT = 2'd1;
    localparam logic [1:0] REG_START  = 2'd2;
    localparam logic [1:0] REG_PREV   = 2'd3;

    // Policy codes
    localparam logic [1:0] POL_FCFS  = 2'd0;
    localparam logic [1:0] POL_SSTF  = 2'd1;
    localparam logic [1:0] POL_SCAN  = 2'd2;
    localparam logic [1:0] POL_CSCAN = 2'd3;

endpackage

// ----- rtl/dhss_seek_acc.sv -----
// Shared distance unit: |target - head| added into a saturating accumulator.
// Depends on dhss_pkg.
module dhss_seek_acc #(
    parameter int CYLINDER_BITS = dhss_pkg::CYLINDER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_clear,
    input  logic [CYLINDER_BITS-1:0]  i_head_init,
    input  logic                      i_move,
    input  logic [CYLINDER_BITS-1:0]  i_target,
    output logic [CYLINDER_BITS-1:0]  o_head,
    output logic [CYLINDER_BITS-1:0]  o_dist,
    output logic [dhss_pkg::SEEK_W-1:0] o_acc
);
    logic [CYLINDER_BITS-1:0]    r_head, n_head;
    logic [dhss_pkg::SEEK_W-1:0] r_acc, n_acc;
    logic [dhss_pkg::SEEK_W:0]   w_sum;
    logic [dhss_pkg::SEEK_W:0]   w_dext;

    // absolute distance from the head
    assign o_dist = (i_target > r_head) ? (i_target - r_head) : (r_head - i_target);
    assign w_dext = (dhss_pkg::SEEK_W + 1)'(o_dist);
    assign w_sum  = {1'b0, r_acc} + w_dext;

    always_comb begin
        n_head = r_head;
        n_acc  = r_acc;
        if (i_clear) begin
            n_head = i_head_init;
            n_acc  = '0;
        end else if (i_move) begin
            n_head = i_target;
            n_acc  = (w_sum > {1'b0, dhss_pkg::SEEK_MAX}) ? dhss_pkg::SEEK_MAX
                                                         : w_sum[dhss_pkg::SEEK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_acc  <= n_acc;
    end

    assign o_head = r_head;
    assign o_acc  = r_acc;
endmodule

// ----- rtl/disk_head_seek_scheduler_top.sv -----
// Disk head seek scheduler top: request store, sequencer, shared seek unit.
// While loading, a beat is taken whenever i_valid is high. After a last beat the block is
// busy with the batch for FCFS, SSTF or SCAN/C-SCAN, each store read being issued in a read
// state first. o_valid rises on return to loading, once the prior beat is gone.
// Throughput: one batch at a time; ready is low while the batch is computed.
// Reset: synchronous active low; clears config to defaults, counts, marks, FSM.
`include "disk_head_seek_scheduler_top_defines.svh"
module disk_head_seek_scheduler_top #(
    parameter int MAX_REQUESTS  = dhss_pkg::MAX_REQUESTS_DEF,
    parameter int CYLINDER_BITS = dhss_pkg::CYLINDER_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [dhss_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [CYLINDER_BITS-1:0]   i_request_cylinder,
    input  logic                       i_last_request,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [dhss_pkg::SEEK_W-1:0]  o_total_seek,
    output logic [dhss_pkg::COUNT_W-1:0] o_request_count,
    output logic                       o_batch_overflow
);
    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int CB = CYLINDER_BITS;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;  // issue read of index r_j
    localparam logic [3:0] S_CMP   = 4'd3;  // data of r_j available
    localparam logic [3:0] S_STEP  = 4'd4;  // SSTF/sort: commit best
    localparam logic [3:0] S_SPLIT = 4'd5;  // sweep: visit sorted list
    localparam logic [3:0] S_EDGE1 = 4'd6;
    localparam logic [3:0] S_EDGE2 = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_SRD   = 4'd9;  // sweep visit read
    localparam logic [3:0] S_SMV   = 4'd10; // sweep visit move

    // configuration
    logic [1:0]                 r_policy;
    logic [dhss_pkg::CFG_W-1:0] r_cylcnt;
    logic [CB-1:0]              r_start, r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= dhss_pkg::POL_FCFS;
            r_cylcnt <= dhss_pkg::CFG_W'(65536);
            r_start  <= '0;
            r_prev   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dhss_pkg::REG_POLICY: r_policy <= i_cfg_data[1:0];
                dhss_pkg::REG_CYLCNT: r_cylcnt <= i_cfg_data;
                dhss_pkg::REG_START:  r_start  <= CB'(i_cfg_data[15:0]);
                dhss_pkg::REG_PREV:   r_prev   <= CB'(i_cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // store (arrival order) and sorted copy
    logic [CB-1:0] mem_req [MAX_REQUESTS];
    logic [CB-1:0] mem_srt [MAX_REQUESTS];
    logic [CB-1:0] r_rdata, r_sdata;
    logic [IW-1:0] w_raddr, w_saddr;
    logic          w_swe;
    logic [IW-1:0] w_swaddr;
    logic [CB-1:0] w_swdata;

    logic [3:0]    r_st, n_st;
    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic [MAX_REQUESTS-1:0] r_mark;
    logic [CW-1:0] r_k, r_j, r_split;
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [CB-1:0] r_bestv, r_bestd;
    logic          r_phase;  // sweep: 0 first leg, 1 second leg
    logic          r_up;
    logic          r_ovld;
    logic [dhss_pkg::SEEK_W-1:0]  r_oseek;
    logic [dhss_pkg::COUNT_W-1:0] r_ocnt;
    logic          r_oovf;

    logic          w_accept, w_full;
    logic [CB-1:0] w_top;
    logic [dhss_pkg::CFG_W-1:0] w_topx;

    // loading continues while a result beat waits in the output register
    assign o_ready  = (r_st == S_LOAD);
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_cnt == CW'(MAX_REQUESTS));
    assign w_topx   = (r_cylcnt == '0) ? '0 : r_cylcnt - 1'b1;
    assign w_top    = CB'(w_topx);

    // shared seek unit
    logic          w_clear, w_move;
    logic [CB-1:0] w_target, w_head, w_dist;
    logic [dhss_pkg::SEEK_W-1:0] w_acc;

    dhss_seek_acc #(.CYLINDER_BITS(CB)) u_acc (
        .i_clk      (i_clk),
        .i_clear    (w_clear),
        .i_head_init(r_start),
        .i_move     (w_move),
        .i_target   (w_target),
        .o_head     (w_head),
        .o_dist     (w_dist),
        .o_acc      (w_acc)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_full) mem_req[r_cnt[IW-1:0]] <= i_request_cylinder;
        r_rdata <= mem_req[w_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_swe) mem_srt[w_swaddr] <= w_swdata;
        r_sdata <= mem_srt[w_saddr];
    end

    // candidate test against the current best
    logic w_cand, w_better, w_sort_pol;
    assign w_sort_pol = r_policy[1];
    assign w_cand     = !r_mark[r_j[IW-1:0]];
    assign w_better   = !r_found ||
                        (w_sort_pol ? (r_rdata < r_bestv) : (w_dist < r_bestd));

    // sweep visit order: index computed from phase and k
    logic [CW-1:0] w_vidx;
    logic [CW-1:0] w_vlen;
    always_comb begin
        w_vidx = '0;
        w_vlen = '0;
        if (r_up) begin
            if (!r_phase) begin
                w_vlen = r_cnt - r_split; w_vidx = r_split + r_k;
            end else if (r_policy == dhss_pkg::POL_CSCAN) begin
                w_vlen = r_split; w_vidx = r_k;
            end else begin
                w_vlen = r_split; w_vidx = r_split - r_k - 1'b1;
            end
        end else begin
            if (!r_phase) begin
                w_vlen = r_split; w_vidx = r_split - r_k - 1'b1;
            end else if (r_policy == dhss_pkg::POL_CSCAN) begin
                w_vlen = r_cnt - r_split; w_vidx = r_cnt - r_k - 1'b1;
            end else begin
                w_vlen = r_cnt - r_split; w_vidx = r_split + r_k;
            end
        end
    end

    assign w_raddr  = r_j[IW-1:0];
    assign w_saddr  = w_vidx[IW-1:0];
    assign w_swe    = (r_st == S_STEP) && w_sort_pol;
    assign w_swaddr = r_k[IW-1:0];
    assign w_swdata = r_bestv;

    // seek unit control
    always_comb begin
        w_clear  = (r_st == S_INIT);
        w_move   = 1'b0;
        w_target = r_rdata;
        case (r_st)
            S_CMP:   begin w_move = (r_policy == dhss_pkg::POL_FCFS); w_target = r_rdata; end
            S_STEP:  begin w_move = (r_policy == dhss_pkg::POL_SSTF); w_target = r_bestv; end
            S_SMV:   begin w_move = 1'b1; w_target = r_sdata; end
            S_EDGE1: begin w_move = 1'b1; w_target = r_up ? w_top : '0; end
            S_EDGE2: begin w_move = (r_policy == dhss_pkg::POL_CSCAN);
                           w_target = r_up ? '0 : w_top; end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_mark <= '0;
            r_ovld <= 1'b0; r_k <= '0; r_j <= '0; r_found <= 1'b0;
            r_split <= '0; r_phase <= 1'b0; r_up <= 1'b0;
        end else begin
            if (o_valid && i_ready) r_ovld <= 1'b0;
            case (r_st)
                S_LOAD: if (w_accept) begin
                    if (w_full) r_ovf <= 1'b1;
                    else r_cnt <= r_cnt + 1'b1;
                    if (i_last_request) r_st <= S_INIT;
                end
                S_INIT: begin
                    r_k <= '0; r_j <= '0; r_found <= 1'b0; r_mark <= '0;
                    r_split <= '0; r_phase <= 1'b0; r_up <= r_prev < r_start;
                    r_st <= S_RD;
                end
                S_RD: r_st <= S_CMP;
                S_CMP: begin
                    if (r_policy == dhss_pkg::POL_FCFS) begin
                        if (r_j + 1'b1 >= r_cnt) r_st <= S_OUT;
                        else begin r_j <= r_j + 1'b1; r_st <= S_RD; end
                    end else begin
                        if (w_cand && w_better) begin
                            r_found <= 1'b1; r_best <= r_j[IW-1:0];
                            r_bestv <= r_rdata; r_bestd <= w_dist;
                        end
                        if (r_j + 1'b1 >= r_cnt) r_st <= S_STEP;
                        else begin r_j <= r_j + 1'b1; r_st <= S_RD; end
                    end
                end
                S_STEP: begin
                    r_mark[r_best] <= 1'b1;
                    if (w_sort_pol && r_bestv < r_start) r_split <= r_split + 1'b1;
                    r_found <= 1'b0; r_j <= '0;
                    if (r_k + 1'b1 >= r_cnt) begin
                        r_k <= '0;
                        r_st <= w_sort_pol ? S_SPLIT : S_OUT;
                    end else begin
                        r_k <= r_k + 1'b1; r_st <= S_RD;
                    end
                end
                S_SPLIT: begin
                    if (r_k >= w_vlen) begin
                        r_k <= '0;
                        r_st <= r_phase ? S_OUT : S_EDGE1;
                    end else r_st <= S_SRD;
                end
                S_SRD: r_st <= S_SMV;
                S_SMV: begin r_k <= r_k + 1'b1; r_st <= S_SPLIT; end
                S_EDGE1: r_st <= S_EDGE2;
                S_EDGE2: begin r_phase <= 1'b1; r_st <= S_SPLIT; end
                S_OUT: if (!r_ovld) begin
                    r_ovld <= 1'b1; r_cnt <= '0; r_ovf <= 1'b0; r_mark <= '0;
                    r_st <= S_LOAD;
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT && !r_ovld) begin
            r_oseek <= w_acc;
            r_ocnt  <= dhss_pkg::COUNT_W'(r_cnt);
            r_oovf  <= r_ovf;
        end
    end

    assign o_valid          = r_ovld;
    assign o_total_seek     = r_oseek;
    assign o_request_count  = r_ocnt;
    assign o_batch_overflow = r_oovf;

    `DHS_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_REQUESTS), "count overflow")
    `DHS_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_st != S_LOAD, !o_ready, "ready while busy")
    `DHS_ASSERT_NEXT(a_last_starts, i_clk, i_rst_n, w_accept && i_last_request, r_st == S_INIT, "no start")
    `DHS_ASSERT_NEXT(a_out_clears, i_clk, i_rst_n, r_st == S_OUT && !r_ovld, r_cnt == '0 && o_valid, "no clear")
    `DHS_ASSERT_NEXT(a_init_head, i_clk, i_rst_n, r_st == S_INIT, w_head == r_start, "head not loaded")
endmodule
